/* rtl/oidbe_pkg.sv */
`default_nettype none
// ============================================================================
// oidbe_pkg
// Shared types and constants of the OID decimal to BER encoder.
// ============================================================================
package oidbe_pkg;

    // default arc width in bits
    localparam int ARC_WIDTH_DEFAULT = 64;

    // entries in the queue between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // input digit width and clamp value
    localparam int              DIGIT_W   = 4;
    localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

    // absolute mode: first arc limit and weight of the first arc
    localparam int       FIRST_ARC_MAX  = 2;
    localparam logic [6:0] FIRST_ARC_MULT = 7'd40;

    // base-128 group width
    localparam int GROUP_W = 7;

    // error codes reported on the last result of an identifier
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_FIRST_ARC = 2'd1,
        ERR_FEW_ARCS  = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } err_code_t;

    // front sequencer states
    typedef enum logic {
        FRONT_ACCEPT,
        FRONT_FINISH
    } front_state_t;

    // control part of one queued job
    typedef struct packed {
        logic      last;
        err_code_t err;
    } job_ctrl_t;

endpackage : oidbe_pkg
`default_nettype wire

/* rtl/oidbe_ifs.sv */
`default_nettype none
// ============================================================================
// oidbe_ifs
// Channel interfaces: digit input, encoded byte output, configuration write.
// ============================================================================
interface oidbe_digit_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit;
    logic       arc_end;
    logic       oid_end;

    modport source (output valid, output digit, output arc_end, output oid_end,
                    input ready);
    modport sink   (input valid, input digit, input arc_end, input oid_end,
                    output ready);
endinterface : oidbe_digit_if

interface oidbe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output last_byte,
                    output error_code, input ready);
    modport sink   (input valid, input out_byte, input last_byte,
                    input error_code, output ready);
endinterface : oidbe_byte_if

interface oidbe_cfg_if;
    logic valid;
    logic ready;
    logic relative_mode;

    modport source (output valid, output relative_mode, input ready);
    modport sink   (input valid, input relative_mode, output ready);
endinterface : oidbe_cfg_if
`default_nettype wire

/* rtl/oidbe_fifo.sv */
`default_nettype none
// ============================================================================
// oidbe_fifo
// Small register FIFO decoupling the front and the back.
// ============================================================================
module oidbe_fifo
    import oidbe_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : oidbe_fifo
`default_nettype wire

/* rtl/oidbe_front.sv */
`default_nettype none
// ============================================================================
// oidbe_front
// Digit accumulator and arc classifier; queues one job per emitted arc, plus an error job ending a failed identifier.
// ============================================================================
module oidbe_front
    import oidbe_pkg::*;
#(
    parameter int ARC_WIDTH = ARC_WIDTH_DEFAULT
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    oidbe_digit_if.sink         digits,
    input  wire logic           relative_mode,
    output logic                push_valid,
    output logic [ARC_WIDTH-1:0] push_value,
    output job_ctrl_t           push_ctrl,
    input  wire logic           push_ready
);

    localparam int SW = ARC_WIDTH + DIGIT_W;

    front_state_t         state_reg, state_next;
    logic [ARC_WIDTH-1:0] arc_value_reg, arc_value_next;
    logic [1:0]           arc_count_reg, arc_count_next;
    logic [1:0]           first_arc_reg, first_arc_next;
    logic [1:0]           first_digits_reg, first_digits_next;
    err_code_t            pend_reg, pend_next;
    logic                 oid_end_reg, oid_end_next;

    logic                 accept;
    logic [DIGIT_W-1:0]   digit_sat;
    logic [SW-1:0]        scaled;
    logic                 scaled_ovf;
    logic [ARC_WIDTH:0]   combined;
    logic [6:0]           first_add;

    err_code_t            fin_err;
    logic                 fin_emit;
    logic [ARC_WIDTH-1:0] fin_value;
    logic [1:0]           fin_first;
    logic                 need_push;
    logic                 finish_go;

    assign accept    = digits.valid && digits.ready;
    assign digit_sat = (digits.digit > MAX_DIGIT) ? MAX_DIGIT : digits.digit;

    // value*10 + digit, with carry bits to catch overflow
    assign scaled = (SW'(arc_value_reg) << 3) + (SW'(arc_value_reg) << 1)
                  + SW'(digit_sat);
    assign scaled_ovf = |scaled[SW-1:ARC_WIDTH];

    assign first_add = 7'(first_arc_reg) * FIRST_ARC_MULT;
    assign combined  = (ARC_WIDTH + 1)'(arc_value_reg) + (ARC_WIDTH + 1)'(first_add);

    // arc end classification from the registered arc
    always_comb
    begin
        fin_err   = pend_reg;
        fin_emit  = 1'b0;
        fin_value = arc_value_reg;
        fin_first = first_arc_reg;
        if (pend_reg == ERR_NONE)
        begin
            if (relative_mode || arc_count_reg >= 2'd2)
            begin
                fin_emit = 1'b1;
            end
            else if (arc_count_reg == 2'd0)
            begin
                if (oid_end_reg)
                begin
                    fin_err = ERR_FEW_ARCS;
                end
                else if (first_digits_reg != 2'd1 ||
                         arc_value_reg > ARC_WIDTH'(FIRST_ARC_MAX))
                begin
                    fin_err = ERR_FIRST_ARC;
                end
                else
                begin
                    fin_first = arc_value_reg[1:0];
                end
            end
            else
            begin
                if (combined[ARC_WIDTH])
                begin
                    fin_err = ERR_OVERFLOW;
                end
                else
                begin
                    fin_emit  = 1'b1;
                    fin_value = combined[ARC_WIDTH-1:0];
                end
            end
        end
    end

    assign need_push      = fin_emit || oid_end_reg;
    assign push_value     = fin_value;
    assign push_ctrl.last = oid_end_reg;
    assign push_ctrl.err  = fin_err;

    // sequencer outputs
    always_comb
    begin
        case (state_reg)
            FRONT_ACCEPT:
            begin
                digits.ready = 1'b1;
                push_valid   = 1'b0;
                finish_go    = 1'b0;
            end
            FRONT_FINISH:
            begin
                digits.ready = 1'b0;
                push_valid   = need_push;
                finish_go    = !need_push || push_ready;
            end
            default:
            begin
                digits.ready = 1'b0;
                push_valid   = 1'b0;
                finish_go    = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FRONT_ACCEPT:
            begin
                if (accept && (digits.arc_end || digits.oid_end))
                begin
                    state_next = FRONT_FINISH;
                end
            end
            FRONT_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = FRONT_ACCEPT;
                end
            end
            default:
            begin
                state_next = FRONT_ACCEPT;
            end
        endcase
    end

    // arc state
    always_comb
    begin
        arc_value_next    = arc_value_reg;
        arc_count_next    = arc_count_reg;
        first_arc_next    = first_arc_reg;
        first_digits_next = first_digits_reg;
        pend_next         = pend_reg;
        oid_end_next      = oid_end_reg;
        if (accept)
        begin
            if (pend_reg == ERR_NONE)
            begin
                if (scaled_ovf)
                begin
                    pend_next = ERR_OVERFLOW;
                end
                else
                begin
                    arc_value_next = scaled[ARC_WIDTH-1:0];
                end
            end
            if (!relative_mode && arc_count_reg == 2'd0 && first_digits_reg != 2'd3)
            begin
                first_digits_next = first_digits_reg + 2'd1;
            end
            oid_end_next = digits.oid_end;
        end
        if (finish_go)
        begin
            arc_value_next = '0;
            if (oid_end_reg)
            begin
                arc_count_next    = 2'd0;
                first_arc_next    = 2'd0;
                first_digits_next = 2'd0;
                pend_next         = ERR_NONE;
            end
            else
            begin
                arc_count_next = (arc_count_reg == 2'd2) ? 2'd2 : arc_count_reg + 2'd1;
                first_arc_next = fin_first;
                pend_next      = fin_err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= FRONT_ACCEPT;
            arc_value_reg    <= '0;
            arc_count_reg    <= 2'd0;
            first_arc_reg    <= 2'd0;
            first_digits_reg <= 2'd0;
            pend_reg         <= ERR_NONE;
            oid_end_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            arc_value_reg    <= arc_value_next;
            arc_count_reg    <= arc_count_next;
            first_arc_reg    <= first_arc_next;
            first_digits_reg <= first_digits_next;
            pend_reg         <= pend_next;
            oid_end_reg      <= oid_end_next;
        end
    end

endmodule : oidbe_front
`default_nettype wire

/* rtl/oidbe_back.sv */
`default_nettype none
// ============================================================================
// oidbe_back
// Byte serializer: turns a queued arc value into base-128 beats.
// ============================================================================
module oidbe_back
    import oidbe_pkg::*;
#(
    parameter int ARC_WIDTH = ARC_WIDTH_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 job_valid,
    output logic                      job_pop,
    input  wire logic [ARC_WIDTH-1:0] job_value,
    input  wire job_ctrl_t            job_ctrl,
    oidbe_byte_if.source              encoded
);

    localparam int GROUPS = (ARC_WIDTH + GROUP_W - 1) / GROUP_W;
    localparam int PW     = GROUPS * GROUP_W;
    localparam int KW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    logic                 busy_reg, busy_next;
    logic [ARC_WIDTH-1:0] value_reg, value_next;
    job_ctrl_t            ctrl_reg, ctrl_next;
    logic [KW-1:0]        k_reg, k_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    err_code_t            out_err_reg, out_err_next;

    logic [PW-1:0]        head_padded;
    logic [PW-1:0]        cur_padded;
    logic [KW-1:0]        head_top;
    logic                 produce;

    assign head_padded = PW'(job_value);
    assign cur_padded  = PW'(value_reg);

    // index of the most significant nonzero group
    always_comb
    begin
        head_top = '0;
        for (int i = 1; i < GROUPS; i++)
        begin
            if (head_padded[i*GROUP_W +: GROUP_W] != '0)
            begin
                head_top = KW'(i);
            end
        end
    end

    assign job_pop = !busy_reg && job_valid;
    assign produce = busy_reg && (!out_valid_reg || encoded.ready);

    always_comb
    begin
        busy_next      = busy_reg;
        value_next     = value_reg;
        ctrl_next      = ctrl_reg;
        k_next         = k_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && !encoded.ready;
        if (job_pop)
        begin
            busy_next  = 1'b1;
            value_next = job_value;
            ctrl_next  = job_ctrl;
            k_next     = (job_ctrl.err != ERR_NONE) ? '0 : head_top;
        end
        if (produce)
        begin
            out_valid_next = 1'b1;
            if (ctrl_reg.err != ERR_NONE)
            begin
                // error closes the identifier with a single zero beat
                out_byte_next = 8'h00;
                out_last_next = 1'b1;
                out_err_next  = ctrl_reg.err;
            end
            else
            begin
                out_byte_next = {(k_reg != '0), cur_padded[k_reg*GROUP_W +: GROUP_W]};
                out_last_next = ctrl_reg.last && (k_reg == '0);
                out_err_next  = ERR_NONE;
            end
            if (k_reg == '0 || ctrl_reg.err != ERR_NONE)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        ctrl_reg     <= ctrl_next;
        k_reg        <= k_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign encoded.valid      = out_valid_reg;
    assign encoded.out_byte   = out_byte_reg;
    assign encoded.last_byte  = out_last_reg;
    assign encoded.error_code = out_err_reg;

endmodule : oidbe_back
`default_nettype wire

/* rtl/oid_decimal_to_ber_encoder_unit.sv */
`default_nettype none
// ============================================================================
// oid_decimal_to_ber_encoder_unit
// Decimal-digit OID in, BER object identifier content bytes out.
// ============================================================================
// Feed an object identifier as decimal digits on the digits channel, most
// significant first, one digit per beat, with arc_end on the last digit of
// each arc and oid_end on the last digit of the identifier (oid_end also ends
// the arc; digits above nine count as nine). Each arc comes out on the
// encoded channel as minimal big-endian base-128 bytes, bit 7 set on all but
// the arc's final byte; last_byte marks the final beat of the identifier. In
// absolute mode (relative_mode = 0) the first arc must be one digit 0..2 and
// is folded into the second as first*40+second; relative mode encodes every
// arc alone. On an error (bad first arc, fewer than two arcs, or an arc that
// does not fit ARC_WIDTH bits) no further bytes go out for that identifier
// and its end produces one beat with out_byte 0, last_byte 1 and the code of
// the first error found; bytes sent before the error was seen stay sent.
// Timing: the front takes one digit per cycle but stops at each arc end to
// classify the arc and queue it, waiting while the queue is full. The back
// loads a queued arc and then emits its ceil(bits/7) bytes, up to
// ceil(ARC_WIDTH/7) (ten at 64 bits), holding while a beat waits to be taken;
// it loads the next arc only after the current arc's last byte. A two-entry
// queue lets the front keep taking digits while the back serializes. The
// encoded output is registered and the front keeps accepting while a beat waits.
// The relative_mode register is written through the cfg channel, which is
// always ready; write it only while no identifier is in flight.
// ============================================================================
module oid_decimal_to_ber_encoder_unit
    import oidbe_pkg::*;
#(
    parameter int ARC_WIDTH = ARC_WIDTH_DEFAULT
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    oidbe_cfg_if.sink    cfg,
    oidbe_digit_if.sink  digits,
    oidbe_byte_if.source encoded
);

    localparam int JOB_W = ARC_WIDTH + $bits(job_ctrl_t);

    // mode register
    logic relative_mode_reg, relative_mode_next;

    // front to queue
    logic                 push_valid;
    logic                 push_ready;
    logic [ARC_WIDTH-1:0] push_value;
    job_ctrl_t            push_ctrl;

    // queue to back
    logic                 job_valid;
    logic                 job_pop;
    logic [JOB_W-1:0]     job_data;
    logic [ARC_WIDTH-1:0] job_value;
    job_ctrl_t            job_ctrl;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        relative_mode_next = relative_mode_reg;
        if (cfg.valid && cfg.ready)
        begin
            relative_mode_next = cfg.relative_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relative_mode_reg <= 1'b0;
        end
        else
        begin
            relative_mode_reg <= relative_mode_next;
        end
    end

    // digit accumulation and arc classification
    oidbe_front #(
        .ARC_WIDTH (ARC_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .digits        (digits),
        .relative_mode (relative_mode_reg),
        .push_valid    (push_valid),
        .push_value    (push_value),
        .push_ctrl     (push_ctrl),
        .push_ready    (push_ready)
    );

    // job queue: {ctrl, value}
    oidbe_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_ctrl, push_value}),
        .pop_valid  (job_valid),
        .pop_ready  (job_pop),
        .pop_data   (job_data)
    );

    assign job_value = job_data[ARC_WIDTH-1:0];
    assign job_ctrl  = job_ctrl_t'(job_data[JOB_W-1:ARC_WIDTH]);

    // base-128 serializer
    oidbe_back #(
        .ARC_WIDTH (ARC_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job_value (job_value),
        .job_ctrl  (job_ctrl),
        .encoded   (encoded)
    );

endmodule : oid_decimal_to_ber_encoder_unit
`default_nettype wire
